@@ hw/rtl/assert_macros.svh @@
// assertion macros for the rtl files; included by the top level
// expects clk and rst_n to be visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/rlc_pkg.sv @@
// shared types and constants of the rectangle line clipper
// no dependencies; imported by rlc_ctrl, rlc_dp and the top level
package rlc_pkg;

    // window register indexes on the configuration port
    localparam logic [1:0] REG_XMIN = 2'd0;
    localparam logic [1:0] REG_YMIN = 2'd1;
    localparam logic [1:0] REG_XMAX = 2'd2;
    localparam logic [1:0] REG_YMAX = 2'd3;

    // window reset values
    localparam int WIN_XMIN_RESET = 0;
    localparam int WIN_YMIN_RESET = 0;
    localparam int WIN_XMAX_RESET = 639;
    localparam int WIN_YMAX_RESET = 479;

    // outcode bit positions
    localparam int OC_LEFT   = 0;
    localparam int OC_RIGHT  = 1;
    localparam int OC_BOTTOM = 2;
    localparam int OC_TOP    = 3;

    // endpoint moves allowed before giving up
    localparam int           MOVE_BITS = 4;
    localparam logic [3:0]   MAX_MOVES = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_PREP,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_UPDATE,
        ST_DONE
    } rlc_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic prep;
        logic mul;
        logic div_init;
        logic div_step;
        logic update;
        logic load_out;
        logic accept;
    } rlc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic both_inside;
        logic share_bit;
        logic div_last;
    } rlc_stat_t;

endpackage

@@ hw/rtl/rlc_ctrl.sv @@
// controller state machine of the rectangle line clipper
// depends on rlc_pkg; drives rlc_dp through rlc_cmd_t
module rlc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  rlc_pkg::rlc_stat_t stat,
    output rlc_pkg::rlc_cmd_t  cmd
);
    import rlc_pkg::*;

    rlc_state_t           state_reg, state_next;
    logic [MOVE_BITS-1:0] moves_reg, moves_next;
    logic                 acc_reg, acc_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_TEST;
            end
            ST_TEST:
            begin
                if (stat.both_inside || stat.share_bit || moves_reg >= MAX_MOVES)
                    state_next = ST_DONE;
                else
                    state_next = ST_PREP;
            end
            ST_PREP:     state_next = ST_MUL;
            ST_MUL:      state_next = ST_DIV_INIT;
            ST_DIV_INIT: state_next = ST_DIV;
            ST_DIV:
            begin
                if (stat.div_last)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:   state_next = ST_TEST;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs and counters
    always_comb
    begin
        cmd            = '0;
        s_tready       = 1'b0;
        moves_next     = moves_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
                moves_next  = '0;
            end
            ST_TEST:
            begin
                acc_next = stat.both_inside;
                if (!stat.both_inside && !stat.share_bit && moves_reg < MAX_MOVES)
                    moves_next = moves_reg + 1'b1;
            end
            ST_PREP:     cmd.prep     = 1'b1;
            ST_MUL:      cmd.mul      = 1'b1;
            ST_DIV_INIT: cmd.div_init = 1'b1;
            ST_DIV:      cmd.div_step = 1'b1;
            ST_UPDATE:   cmd.update   = 1'b1;
            ST_DONE:
            begin
                cmd.accept = acc_reg;
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            moves_reg     <= '0;
            acc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            moves_reg     <= moves_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hw/rtl/rlc_dp.sv @@
// datapath of the rectangle line clipper: window registers, endpoints,
// outcodes, crossing multiplier and restoring divider; depends on rlc_pkg
module rlc_dp #(
    parameter int W = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_addr,
    input  logic [W-1:0]        cfg_data,
    input  logic signed [W-1:0] start_x,
    input  logic signed [W-1:0] start_y,
    input  logic signed [W-1:0] end_x,
    input  logic signed [W-1:0] end_y,
    input  rlc_pkg::rlc_cmd_t   cmd,
    output rlc_pkg::rlc_stat_t  stat,
    output logic                accepted,
    output logic signed [W-1:0] clip_start_x,
    output logic signed [W-1:0] clip_start_y,
    output logic signed [W-1:0] clip_end_x,
    output logic signed [W-1:0] clip_end_y
);
    import rlc_pkg::*;

    localparam int DW = W + 1;
    localparam int PW = 2 * DW;
    localparam int CW = $clog2(PW + 1);

    logic signed [W-1:0]  xmin_reg, ymin_reg, xmax_reg, ymax_reg;
    logic signed [W-1:0]  x0_reg, y0_reg, x1_reg, y1_reg;
    logic [3:0]           c0, c1, csel;
    logic signed [DW-1:0] dx, dy;
    logic signed [DW-1:0] a_reg, b_reg, den_reg;
    logic signed [W-1:0]  base_reg, edge_reg;
    logic                 vert_reg, mv0_reg;
    logic signed [PW-1:0] prod_reg;
    logic [PW-1:0]        quo_reg;
    logic [DW-1:0]        rem_reg, dmag_reg;
    logic                 neg_reg;
    logic [CW-1:0]        cnt_reg;
    logic [DW:0]          rem_sh;
    logic                 ge;
    logic [PW-1:0]        qs;
    logic signed [W-1:0]  nc;
    logic                 acc_out_reg;
    logic signed [W-1:0]  ox0_reg, oy0_reg, ox1_reg, oy1_reg;

    function automatic logic [3:0] outcode(
        input logic signed [W-1:0] x,
        input logic signed [W-1:0] y,
        input logic signed [W-1:0] xl,
        input logic signed [W-1:0] yb,
        input logic signed [W-1:0] xr,
        input logic signed [W-1:0] yt
    );
        logic [3:0] c;
        c            = '0;
        c[OC_TOP]    = y > yt;
        c[OC_BOTTOM] = y < yb;
        c[OC_RIGHT]  = x > xr;
        c[OC_LEFT]   = x < xl;
        return c;
    endfunction

    // window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xmin_reg <= W'(WIN_XMIN_RESET);
            ymin_reg <= W'(WIN_YMIN_RESET);
            xmax_reg <= W'(WIN_XMAX_RESET);
            ymax_reg <= W'(WIN_YMAX_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_XMIN: xmin_reg <= cfg_data;
                REG_YMIN: ymin_reg <= cfg_data;
                REG_XMAX: xmax_reg <= cfg_data;
                REG_YMAX: ymax_reg <= cfg_data;
                default:  xmin_reg <= xmin_reg;
            endcase
        end
    end

    // outcodes and decision status
    assign c0   = outcode(x0_reg, y0_reg, xmin_reg, ymin_reg, xmax_reg, ymax_reg);
    assign c1   = outcode(x1_reg, y1_reg, xmin_reg, ymin_reg, xmax_reg, ymax_reg);
    assign csel = (c0 != 4'd0) ? c0 : c1;
    assign dx   = DW'(x1_reg) - DW'(x0_reg);
    assign dy   = DW'(y1_reg) - DW'(y0_reg);

    assign stat.both_inside = (c0 | c1) == 4'd0;
    assign stat.share_bit   = (c0 & c1) != 4'd0;
    assign stat.div_last    = cnt_reg == CW'(1);

    // divider step and signed quotient
    assign rem_sh = {rem_reg, quo_reg[PW-1]};
    assign ge     = rem_sh >= {1'b0, dmag_reg};
    assign qs     = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign nc     = base_reg + qs[W-1:0];

    // endpoint load and update, edge selection, product and division
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x0_reg <= start_x;
            y0_reg <= start_y;
            x1_reg <= end_x;
            y1_reg <= end_y;
        end
        else if (cmd.update)
        begin
            if (mv0_reg)
            begin
                x0_reg <= vert_reg ? nc : edge_reg;
                y0_reg <= vert_reg ? edge_reg : nc;
            end
            else
            begin
                x1_reg <= vert_reg ? nc : edge_reg;
                y1_reg <= vert_reg ? edge_reg : nc;
            end
        end

        if (cmd.prep)
        begin
            mv0_reg <= c0 != 4'd0;
            if (csel[OC_TOP] || csel[OC_BOTTOM])
            begin
                edge_reg <= csel[OC_TOP] ? ymax_reg : ymin_reg;
                vert_reg <= 1'b1;
                a_reg    <= dx;
                b_reg    <= DW'(csel[OC_TOP] ? ymax_reg : ymin_reg) - DW'(y0_reg);
                den_reg  <= dy;
                base_reg <= x0_reg;
            end
            else
            begin
                edge_reg <= csel[OC_RIGHT] ? xmax_reg : xmin_reg;
                vert_reg <= 1'b0;
                a_reg    <= dy;
                b_reg    <= DW'(csel[OC_RIGHT] ? xmax_reg : xmin_reg) - DW'(x0_reg);
                den_reg  <= dx;
                base_reg <= y0_reg;
            end
        end

        if (cmd.mul)
            prod_reg <= a_reg * b_reg;

        if (cmd.div_init)
        begin
            neg_reg  <= prod_reg[PW-1] ^ den_reg[DW-1];
            quo_reg  <= prod_reg[PW-1] ? (~prod_reg + 1'b1) : prod_reg;
            dmag_reg <= den_reg[DW-1] ? (~den_reg + 1'b1) : den_reg;
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? DW'(rem_sh - {1'b0, dmag_reg}) : rem_sh[DW-1:0];
            quo_reg <= {quo_reg[PW-2:0], ge};
        end

        // result payload
        if (cmd.load_out)
        begin
            acc_out_reg <= cmd.accept;
            ox0_reg     <= cmd.accept ? x0_reg : '0;
            oy0_reg     <= cmd.accept ? y0_reg : '0;
            ox1_reg     <= cmd.accept ? x1_reg : '0;
            oy1_reg     <= cmd.accept ? y1_reg : '0;
        end
    end

    // divider step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.div_init)
            cnt_reg <= CW'(PW);
        else if (cmd.div_step && cnt_reg != '0)
            cnt_reg <= cnt_reg - 1'b1;
    end

    assign accepted     = acc_out_reg;
    assign clip_start_x = ox0_reg;
    assign clip_start_y = oy0_reg;
    assign clip_end_x   = ox1_reg;
    assign clip_end_y   = oy1_reg;

endmodule

@@ hw/rtl/rectangle_line_clipper.sv @@
// a segment takes k endpoint moves, at most 4 for a well-formed window and 8 otherwise
// each move runs the bit-serial restoring divider: one quotient bit per cycle
// a new segment can be taken in the cycle after the result is loaded into the output register
// reset: asynchronous active low; window returns to 0,0 .. 639,479, no result pending
module rectangle_line_clipper #(
    parameter int COORD_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_addr,
    input  logic [COORD_BITS-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // start_x, start_y, end_x, end_y, zero fill
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // clip_start_x, clip_start_y, clip_end_x, clip_end_y, zero fill
    output logic [((4*COORD_BITS+7)/8)*8-1:0] m_tdata,
    // accepted
    output logic                  m_tuser
);
    import rlc_pkg::*;

    `include "assert_macros.svh"

    localparam int W   = COORD_BITS;
    localparam int TDW = ((4 * W + 7) / 8) * 8;

    rlc_cmd_t            cmd;
    rlc_stat_t           stat;
    logic signed [W-1:0] cx0, cy0, cx1, cy1;

    rlc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rlc_dp #(
        .W (W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .start_x      (s_tdata[W-1:0]),
        .start_y      (s_tdata[2*W-1:W]),
        .end_x        (s_tdata[3*W-1:2*W]),
        .end_y        (s_tdata[4*W-1:3*W]),
        .cmd          (cmd),
        .stat         (stat),
        .accepted     (m_tuser),
        .clip_start_x (cx0),
        .clip_start_y (cy0),
        .clip_end_x   (cx1),
        .clip_end_y   (cy1)
    );

    // pack result coordinates
    assign m_tdata = TDW'({cy1, cx1, cy0, cx0});

    `ASSERT_SAME(a_reject_zero, m_tvalid && !m_tuser, m_tdata == '0, "rejected segment with nonzero coordinates")
    `ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second segment taken while busy")

endmodule
